// ===== src/tacp_pkg.sv =====
// Shared types and constants for the topology-aware idle core picker.
package tacp_pkg;

    localparam int NUM_CIDS = 64;
    localparam int ID_W = 6;
    localparam int CNT_W = 7;
    localparam int ID_SPAN = 64;
    localparam int TBL_DEPTH = 64;

    localparam logic [ID_SPAN-1:0] VALID_IDS =
        ID_SPAN'((65'(1) << NUM_CIDS) - 65'(1));
    localparam logic [CNT_W-1:0] CNT_ALL = CNT_W'(ID_SPAN);
    localparam logic [CNT_W-1:0] LIM_MAX = CNT_W'(NUM_CIDS);

    localparam logic [1:0] REG_SEARCH_ALL = 2'd0;
    localparam logic [1:0] REG_PRIMARY_MASK = 2'd1;
    localparam logic [1:0] REG_CID_COUNT = 2'd2;

    typedef enum logic [1:0] {
        OP_MARK_IDLE = 2'd0,
        OP_MARK_BUSY = 2'd1,
        OP_LOAD      = 2'd2,
        OP_PICK      = 2'd3
    } tacp_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_PREV_LOAD,
        ST_PREV_CORE,
        ST_WSCAN_PICK,
        ST_WSCAN_CHECK,
        ST_PREV_ANY,
        ST_SCAN_LLC,
        ST_SCAN_ALL,
        ST_EMIT
    } tacp_state_t;

    typedef struct packed {
        tacp_op_t           opcode;
        logic [ID_W-1:0]    cid;
        logic               prev_valid;
        logic [ID_SPAN-1:0] allowed_mask;
        logic               whole_core;
        logic               pinned;
        logic [ID_W-1:0]    core_first;
        logic [CNT_W-1:0]   core_size;
        logic [ID_W-1:0]    llc_first;
        logic [CNT_W-1:0]   llc_size;
    } tacp_req_t;

    typedef struct packed {
        logic            found;
        logic [ID_W-1:0] picked_cid;
        logic            same_llc;
    } tacp_rsp_t;

    typedef struct packed {
        logic [ID_W-1:0]  core_lo;
        logic [CNT_W-1:0] core_count;
        logic [ID_W-1:0]  llc_lo;
        logic [CNT_W-1:0] llc_count;
    } tacp_topo_t;

    typedef struct packed {
        logic               search_all;
        logic [ID_SPAN-1:0] primary_mask;
        logic [CNT_W-1:0]   lim;
    } tacp_cfg_t;

    typedef struct packed {
        logic            we;
        logic [ID_W-1:0] waddr;
        tacp_topo_t      wdata;
        logic [ID_W-1:0] raddr;
    } tacp_ram_req_t;

    typedef struct packed {
        logic [ID_W-1:0]    base;
        logic [CNT_W-1:0]   cnt;
        logic [CNT_W-1:0]   lim;
        logic [ID_SPAN-1:0] sel;
        logic [ID_SPAN-1:0] idle;
    } tacp_scan_req_t;

    typedef struct packed {
        logic            hit;
        logic [ID_W-1:0] idx;
        logic            all_set;
    } tacp_scan_rsp_t;

endpackage

// ===== src/tacp_topo_ram.sv =====
// Topology table memory: one write port, one registered read port.
module tacp_topo_ram (
    input  logic                    clk,
    input  tacp_pkg::tacp_ram_req_t req,
    output tacp_pkg::tacp_topo_t    rdata
);

    tacp_pkg::tacp_topo_t mem [tacp_pkg::TBL_DEPTH];
    tacp_pkg::tacp_topo_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/tacp_scan_unit.sv =====
// Shared range unit: range mask, lowest-hit search and whole-range idle check.
module tacp_scan_unit (
    input  tacp_pkg::tacp_scan_req_t req,
    output tacp_pkg::tacp_scan_rsp_t rsp
);

    logic [7:0]                      end_pos;
    logic [tacp_pkg::ID_SPAN-1:0]    ge_base;
    logic [tacp_pkg::ID_SPAN-1:0]    lt_end;
    logic [tacp_pkg::ID_SPAN-1:0]    lt_lim;
    logic [tacp_pkg::ID_SPAN-1:0]    span;
    logic [tacp_pkg::ID_SPAN-1:0]    hits;
    logic [tacp_pkg::ID_SPAN-1:0]    gaps;

    always_comb
    begin
        end_pos = {2'b00, req.base} + {1'b0, req.cnt};
        ge_base = {tacp_pkg::ID_SPAN{1'b1}} << req.base;
        lt_end  = (end_pos >= 8'(tacp_pkg::ID_SPAN)) ? {tacp_pkg::ID_SPAN{1'b1}}
                : ~({tacp_pkg::ID_SPAN{1'b1}} << end_pos[tacp_pkg::ID_W-1:0]);
        lt_lim  = (req.lim >= tacp_pkg::CNT_ALL) ? {tacp_pkg::ID_SPAN{1'b1}}
                : ~({tacp_pkg::ID_SPAN{1'b1}} << req.lim[tacp_pkg::ID_W-1:0]);
        span    = ge_base & lt_end & lt_lim;
        hits    = span & req.sel;
        gaps    = span & ~req.idle;

        rsp.hit = |hits;
        rsp.idx = '0;
        for (int i = tacp_pkg::ID_SPAN - 1; i >= 0; i--)
        begin
            if (hits[i])
            begin
                rsp.idx = tacp_pkg::ID_W'(i);
            end
        end
        rsp.all_set = (req.cnt != '0) && (end_pos <= 8'(tacp_pkg::ID_SPAN))
                      && (gaps == '0);
    end

endmodule

// ===== src/tacp_ctrl.sv =====
// Sequencer: idle bitmap, pick search order and response register.
module tacp_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_ready,
    input  tacp_pkg::tacp_req_t      req_data,
    output logic                     rsp_valid,
    input  logic                     rsp_ready,
    output tacp_pkg::tacp_rsp_t      rsp_data,
    input  tacp_pkg::tacp_cfg_t      cfg,
    output tacp_pkg::tacp_ram_req_t  ram_req,
    input  tacp_pkg::tacp_topo_t     ram_rdata,
    output tacp_pkg::tacp_scan_req_t scan_req,
    input  tacp_pkg::tacp_scan_rsp_t scan_rsp
);

    tacp_pkg::tacp_state_t        state_reg, state_next;
    tacp_pkg::tacp_req_t          item_reg, item_next;
    logic [tacp_pkg::ID_SPAN-1:0] idle_reg, idle_next;
    tacp_pkg::tacp_topo_t         prev_reg, prev_next;
    logic                         topo_reg, topo_next;
    logic                         dom_pri_reg, dom_pri_next;
    logic                         phase_all_reg, phase_all_next;
    logic [tacp_pkg::ID_SPAN-1:0] rej_reg, rej_next;
    logic [tacp_pkg::ID_W-1:0]    cur_reg, cur_next;
    tacp_pkg::tacp_rsp_t          res_reg, res_next;
    logic                         rsp_valid_reg, rsp_valid_next;
    tacp_pkg::tacp_rsp_t          rsp_data_reg, rsp_data_next;

    logic [tacp_pkg::ID_SPAN-1:0] dom_mask;
    logic [tacp_pkg::ID_SPAN-1:0] avail;
    logic [tacp_pkg::ID_SPAN-1:0] cid_bit;
    logic                         prev_avail;
    logic                         topo_now;
    logic                         claim_en;
    logic [tacp_pkg::ID_W-1:0]    claim_id;
    logic                         claim_same;
    logic                         dom_fail;
    logic                         emit_ok;
    logic [7:0]                   llc_end;

    // decisions and shared unit operands
    always_comb
    begin
        dom_mask   = dom_pri_reg ? cfg.primary_mask : {tacp_pkg::ID_SPAN{1'b1}};
        avail      = idle_reg & item_reg.allowed_mask & dom_mask;
        cid_bit    = tacp_pkg::ID_SPAN'(1) << item_reg.cid;
        prev_avail = avail[item_reg.cid];
        topo_now   = item_reg.prev_valid && ({1'b0, item_reg.cid} < cfg.lim);
        emit_ok    = !rsp_valid_reg || rsp_ready;

        scan_req.base = '0;
        scan_req.cnt  = '0;
        scan_req.lim  = '0;
        scan_req.sel  = '0;
        scan_req.idle = idle_reg;

        claim_en = 1'b0;
        claim_id = item_reg.cid;
        dom_fail = 1'b0;

        case (state_reg)
            tacp_pkg::ST_EXEC:
            begin
                claim_en = (item_reg.opcode == tacp_pkg::OP_PICK) && item_reg.pinned
                           && idle_reg[item_reg.cid];
            end
            tacp_pkg::ST_PREV_CORE:
            begin
                scan_req.base = prev_reg.core_lo;
                scan_req.cnt  = prev_reg.core_count;
                scan_req.lim  = tacp_pkg::CNT_ALL;
                claim_en      = prev_avail && scan_rsp.all_set;
            end
            tacp_pkg::ST_WSCAN_PICK:
            begin
                scan_req.base = phase_all_reg ? '0 : prev_reg.llc_lo;
                scan_req.cnt  = phase_all_reg ? tacp_pkg::CNT_ALL : prev_reg.llc_count;
                scan_req.lim  = cfg.lim;
                scan_req.sel  = avail & ~rej_reg;
                dom_fail      = !scan_rsp.hit && phase_all_reg;
            end
            tacp_pkg::ST_WSCAN_CHECK:
            begin
                scan_req.base = ram_rdata.core_lo;
                scan_req.cnt  = ram_rdata.core_count;
                scan_req.lim  = tacp_pkg::CNT_ALL;
                claim_en      = scan_rsp.all_set;
                claim_id      = cur_reg;
            end
            tacp_pkg::ST_PREV_ANY:
            begin
                claim_en = prev_avail;
            end
            tacp_pkg::ST_SCAN_LLC:
            begin
                scan_req.base = prev_reg.llc_lo;
                scan_req.cnt  = prev_reg.llc_count;
                scan_req.lim  = cfg.lim;
                scan_req.sel  = avail;
                claim_en      = scan_rsp.hit;
                claim_id      = scan_rsp.idx;
            end
            tacp_pkg::ST_SCAN_ALL:
            begin
                scan_req.cnt  = tacp_pkg::CNT_ALL;
                scan_req.lim  = cfg.lim;
                scan_req.sel  = avail;
                claim_en      = scan_rsp.hit;
                claim_id      = scan_rsp.idx;
                dom_fail      = !scan_rsp.hit;
            end
            default:
            begin
                claim_en = 1'b0;
            end
        endcase

        llc_end    = {2'b00, prev_reg.llc_lo} + {1'b0, prev_reg.llc_count};
        claim_same = topo_reg && (state_reg != tacp_pkg::ST_EXEC)
                     && (claim_id >= prev_reg.llc_lo)
                     && ({2'b00, claim_id} < llc_end);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tacp_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = tacp_pkg::ST_EXEC;
                end
            end
            tacp_pkg::ST_EXEC:
            begin
                if ((item_reg.opcode != tacp_pkg::OP_PICK) || item_reg.pinned)
                begin
                    state_next = tacp_pkg::ST_EMIT;
                end
                else if (topo_now)
                begin
                    state_next = tacp_pkg::ST_PREV_LOAD;
                end
                else
                begin
                    state_next = tacp_pkg::ST_SCAN_ALL;
                end
            end
            tacp_pkg::ST_PREV_LOAD:
            begin
                state_next = tacp_pkg::ST_PREV_CORE;
            end
            tacp_pkg::ST_PREV_CORE:
            begin
                state_next = claim_en ? tacp_pkg::ST_EMIT : tacp_pkg::ST_WSCAN_PICK;
            end
            tacp_pkg::ST_WSCAN_PICK:
            begin
                if (scan_rsp.hit)
                begin
                    state_next = tacp_pkg::ST_WSCAN_CHECK;
                end
                else if (!phase_all_reg && !item_reg.whole_core)
                begin
                    state_next = tacp_pkg::ST_PREV_ANY;
                end
            end
            tacp_pkg::ST_WSCAN_CHECK:
            begin
                state_next = claim_en ? tacp_pkg::ST_EMIT : tacp_pkg::ST_WSCAN_PICK;
            end
            tacp_pkg::ST_PREV_ANY:
            begin
                state_next = claim_en ? tacp_pkg::ST_EMIT : tacp_pkg::ST_SCAN_LLC;
            end
            tacp_pkg::ST_SCAN_LLC:
            begin
                state_next = claim_en ? tacp_pkg::ST_EMIT : tacp_pkg::ST_SCAN_ALL;
            end
            tacp_pkg::ST_SCAN_ALL:
            begin
                if (claim_en)
                begin
                    state_next = tacp_pkg::ST_EMIT;
                end
            end
            tacp_pkg::ST_EMIT:
            begin
                if (emit_ok)
                begin
                    state_next = tacp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tacp_pkg::ST_IDLE;
            end
        endcase

        // domain exhausted: retry everywhere or give up
        if (dom_fail)
        begin
            if (dom_pri_reg)
            begin
                state_next = topo_reg ? tacp_pkg::ST_PREV_CORE : tacp_pkg::ST_SCAN_ALL;
            end
            else
            begin
                state_next = tacp_pkg::ST_EMIT;
            end
        end
    end

    // datapath and outputs
    always_comb
    begin
        item_next      = item_reg;
        idle_next      = idle_reg;
        prev_next      = prev_reg;
        topo_next      = topo_reg;
        dom_pri_next   = dom_pri_reg;
        phase_all_next = phase_all_reg;
        rej_next       = rej_reg;
        cur_next       = cur_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;

        req_ready = (state_reg == tacp_pkg::ST_IDLE);

        ram_req.we               = 1'b0;
        ram_req.waddr            = item_reg.cid;
        ram_req.wdata.core_lo    = item_reg.core_first;
        ram_req.wdata.core_count = item_reg.core_size;
        ram_req.wdata.llc_lo     = item_reg.llc_first;
        ram_req.wdata.llc_count  = item_reg.llc_size;
        ram_req.raddr            = item_reg.cid;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            tacp_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    item_next = req_data;
                end
            end
            tacp_pkg::ST_EXEC:
            begin
                res_next = '0;
                case (item_reg.opcode)
                    tacp_pkg::OP_MARK_IDLE:
                    begin
                        idle_next = idle_reg | (cid_bit & tacp_pkg::VALID_IDS);
                    end
                    tacp_pkg::OP_MARK_BUSY:
                    begin
                        idle_next = idle_reg & ~cid_bit;
                    end
                    tacp_pkg::OP_LOAD:
                    begin
                        ram_req.we = 1'b1;
                    end
                    tacp_pkg::OP_PICK:
                    begin
                        topo_next    = topo_now;
                        dom_pri_next = !cfg.search_all;
                    end
                    default:
                    begin
                        res_next = '0;
                    end
                endcase
            end
            tacp_pkg::ST_PREV_LOAD:
            begin
                prev_next = ram_rdata;
            end
            tacp_pkg::ST_PREV_CORE:
            begin
                phase_all_next = 1'b0;
                rej_next       = '0;
            end
            tacp_pkg::ST_WSCAN_PICK:
            begin
                ram_req.raddr = scan_rsp.idx;
                if (scan_rsp.hit)
                begin
                    cur_next = scan_rsp.idx;
                end
                else if (!phase_all_reg && item_reg.whole_core)
                begin
                    phase_all_next = 1'b1;
                    rej_next       = '0;
                end
            end
            tacp_pkg::ST_WSCAN_CHECK:
            begin
                rej_next = rej_reg | (tacp_pkg::ID_SPAN'(1) << cur_reg);
            end
            tacp_pkg::ST_EMIT:
            begin
                if (emit_ok)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_data_next  = res_reg;
                end
            end
            default:
            begin
                cur_next = cur_reg;
            end
        endcase

        if (dom_fail)
        begin
            dom_pri_next = 1'b0;
        end

        if (claim_en)
        begin
            idle_next           = idle_next & ~(tacp_pkg::ID_SPAN'(1) << claim_id);
            res_next.found      = 1'b1;
            res_next.picked_cid = claim_id;
            res_next.same_llc   = claim_same;
        end

        rsp_valid = rsp_valid_reg;
        rsp_data  = rsp_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tacp_pkg::ST_IDLE;
            idle_reg      <= '0;
            topo_reg      <= 1'b0;
            dom_pri_reg   <= 1'b0;
            phase_all_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idle_reg      <= idle_next;
            topo_reg      <= topo_next;
            dom_pri_reg   <= dom_pri_next;
            phase_all_reg <= phase_all_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        prev_reg     <= prev_next;
        rej_reg      <= rej_next;
        cur_reg      <= cur_next;
        res_reg      <= res_next;
        rsp_data_reg <= rsp_data_next;
    end

endmodule

// ===== src/topology_aware_idle_core_picker.sv =====
// Top level of the topology-aware idle core picker: register port and submodules.
//
//  channel  direction  handshake            beat
//  req      in         req_valid/req_ready  tacp_req_t: one op
//  rsp      out        rsp_valid/rsp_ready  tacp_rsp_t: one result per op
//  apb      in         psel/penable/pready  64-bit register write or read
//
// Mark idle, mark busy and table load pass through the exec and emit states from
// accept to result. A pick adds a table read when topology is used, then per domain
// the previous-id steps and the masked scans, and per candidate in whole-core scans
// one table read and one core check.
// The shared range unit and the single table read port serve these steps in turn.
// Reset clears the idle bitmap; the topology table is not cleared.
// A result waiting on rsp_ready holds the sequencer only at the end of the next op.
module topology_aware_idle_core_picker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  tacp_pkg::tacp_req_t  req_data,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output tacp_pkg::tacp_rsp_t  rsp_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [63:0]          pwdata,
    output logic [63:0]          prdata,
    output logic                 pready
);

    logic                          search_all_reg, search_all_next;
    logic [tacp_pkg::ID_SPAN-1:0]  primary_mask_reg, primary_mask_next;
    logic [tacp_pkg::CNT_W-1:0]    cid_count_reg, cid_count_next;

    logic [1:0]                    reg_idx;
    logic                          wr_en;
    tacp_pkg::tacp_cfg_t           cfg;
    tacp_pkg::tacp_ram_req_t       ram_req;
    tacp_pkg::tacp_topo_t          ram_rdata;
    tacp_pkg::tacp_scan_req_t      scan_req;
    tacp_pkg::tacp_scan_rsp_t      scan_rsp;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];
    assign wr_en   = psel && penable && pwrite;

    always_comb
    begin
        search_all_next   = search_all_reg;
        primary_mask_next = primary_mask_reg;
        cid_count_next    = cid_count_reg;
        prdata            = '0;

        case (reg_idx)
            tacp_pkg::REG_SEARCH_ALL:
            begin
                prdata = {63'd0, search_all_reg};
                if (wr_en)
                begin
                    search_all_next = pwdata[0];
                end
            end
            tacp_pkg::REG_PRIMARY_MASK:
            begin
                prdata = primary_mask_reg;
                if (wr_en)
                begin
                    primary_mask_next = pwdata;
                end
            end
            tacp_pkg::REG_CID_COUNT:
            begin
                prdata = {57'd0, cid_count_reg};
                if (wr_en)
                begin
                    cid_count_next = pwdata[tacp_pkg::CNT_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase

        cfg.search_all   = search_all_reg;
        cfg.primary_mask = primary_mask_reg;
        cfg.lim          = (cid_count_reg > tacp_pkg::LIM_MAX) ? tacp_pkg::LIM_MAX
                         : cid_count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_all_reg   <= 1'b1;
            primary_mask_reg <= '0;
            cid_count_reg    <= tacp_pkg::CNT_ALL;
        end
        else
        begin
            search_all_reg   <= search_all_next;
            primary_mask_reg <= primary_mask_next;
            cid_count_reg    <= cid_count_next;
        end
    end

    tacp_topo_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    tacp_scan_unit u_scan (
        .req (scan_req),
        .rsp (scan_rsp)
    );

    tacp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .cfg       (cfg),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata),
        .scan_req  (scan_req),
        .scan_rsp  (scan_rsp)
    );

endmodule

// ===== test/tb_top.sv =====
// Testbench for the idle core picker: directed and random op streams checked against a built-in predictor.
module tb_top;

    localparam int LIMIT = 3_000_000;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 40;

    class core_pick_tracker;
        logic [63:0]         idle_map;
        int                  core_lo[64];
        int                  core_len[64];
        int                  llc_lo[64];
        int                  llc_len[64];
        bit                  all_dom;
        logic [63:0]         pref_dom;
        int                  id_count;
        tacp_pkg::tacp_rsp_t owed[$];
        int                  errors;
        int                  n_ops;
        int                  n_picks;
        int                  n_found;
        int                  n_same;

        function new();
            idle_map = '0;
            all_dom = 1'b1;
            pref_dom = '0;
            id_count = 64;
            errors = 0;
            n_ops = 0;
            n_picks = 0;
            n_found = 0;
            n_same = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [63:0] v);
            case (idx)
                tacp_pkg::REG_SEARCH_ALL:   all_dom = v[0];
                tacp_pkg::REG_PRIMARY_MASK: pref_dom = v;
                tacp_pkg::REG_CID_COUNT:    id_count = int'(v[6:0]);
                default:                    ;
            endcase
        endfunction

        function int outstanding();
            return owed.size();
        endfunction

        function bit is_free(int id);
            return id >= 0 && id < tacp_pkg::NUM_CIDS && idle_map[id];
        endfunction

        function bit take(int id);
            if (!is_free(id))
                return 1'b0;
            idle_map[id] = 1'b0;
            return 1'b1;
        endfunction

        function bit core_free(int base, int nr);
            if (nr == 0)
                return 1'b0;
            for (int i = 0; i < nr; i++)
                if (!is_free(base + i))
                    return 1'b0;
            return 1'b1;
        endfunction

        function int scan_top();
            return id_count > tacp_pkg::NUM_CIDS ? tacp_pkg::NUM_CIDS : id_count;
        endfunction

        function bit in_mask(logic [63:0] m, int id);
            return id >= 0 && id < 64 && m[id];
        endfunction

        function bit sweep(logic [63:0] ok, logic [63:0] dom, int base, int nr, bit whole,
                           output int got);
            int lim;
            int id;
            lim = scan_top();
            got = 0;
            for (int i = 0; i < nr; i++)
            begin
                id = base + i;
                if (id >= lim)
                    break;
                if (!is_free(id))
                    continue;
                if (whole && !core_free(core_lo[id], core_len[id]))
                    continue;
                if (!in_mask(ok, id) || !in_mask(dom, id))
                    continue;
                if (take(id))
                begin
                    got = id;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function bit search(logic [63:0] ok, logic [63:0] dom, bit topo, int prev,
                            bit whole_only, output int got);
            int lb;
            int ln;
            bit usable;
            got = 0;
            if (!topo)
                return sweep(ok, dom, 0, scan_top(), 1'b0, got);
            lb = llc_lo[prev];
            ln = llc_len[prev];
            usable = in_mask(ok, prev) && in_mask(dom, prev);
            if (usable && core_free(core_lo[prev], core_len[prev]))
            begin
                if (take(prev))
                begin
                    got = prev;
                    return 1'b1;
                end
            end
            if (sweep(ok, dom, lb, ln, 1'b1, got))
                return 1'b1;
            if (whole_only)
                return sweep(ok, dom, 0, scan_top(), 1'b1, got);
            if (usable)
            begin
                if (take(prev))
                begin
                    got = prev;
                    return 1'b1;
                end
            end
            if (sweep(ok, dom, lb, ln, 1'b0, got))
                return 1'b1;
            return sweep(ok, dom, 0, scan_top(), 1'b0, got);
        endfunction

        function void note_op(tacp_pkg::tacp_req_t r);
            tacp_pkg::tacp_rsp_t e;
            int                  got;
            int                  prev;
            bit                  hit;
            bit                  topo;
            e = '0;
            got = 0;
            prev = int'(r.cid);
            n_ops++;
            case (r.opcode)
                tacp_pkg::OP_MARK_IDLE: idle_map[prev] = 1'b1;
                tacp_pkg::OP_MARK_BUSY: idle_map[prev] = 1'b0;
                tacp_pkg::OP_LOAD:
                begin
                    core_lo[prev] = int'(r.core_first);
                    core_len[prev] = int'(r.core_size);
                    llc_lo[prev] = int'(r.llc_first);
                    llc_len[prev] = int'(r.llc_size);
                end
                tacp_pkg::OP_PICK:
                begin
                    n_picks++;
                    if (r.pinned)
                    begin
                        if (take(prev))
                        begin
                            e.found = 1'b1;
                            e.picked_cid = r.cid;
                        end
                    end
                    else
                    begin
                        topo = r.prev_valid && prev < scan_top();
                        hit = 1'b0;
                        if (!all_dom)
                            hit = search(r.allowed_mask, pref_dom, topo, prev,
                                         r.whole_core, got);
                        if (!hit)
                            hit = search(r.allowed_mask, '1, topo, prev, r.whole_core, got);
                        if (hit)
                        begin
                            e.found = 1'b1;
                            e.picked_cid = 6'(got);
                            e.same_llc = topo && got >= llc_lo[prev]
                                         && got < llc_lo[prev] + llc_len[prev];
                        end
                    end
                    if (e.found)
                        n_found++;
                    if (e.same_llc)
                        n_same++;
                end
                default: ;
            endcase
            owed.push_back(e);
        endfunction

        function void check_result(tacp_pkg::tacp_rsp_t got);
            tacp_pkg::tacp_rsp_t want;
            if (owed.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result found=%0d cid=%0d same_llc=%0d",
                         $time, got.found, got.picked_cid, got.same_llc);
                return;
            end
            want = owed.pop_front();
            if (got.found !== want.found)
            begin
                errors++;
                $display("%0t: found expected %0d actual %0d", $time, want.found, got.found);
            end
            if (got.picked_cid !== want.picked_cid)
            begin
                errors++;
                $display("%0t: picked_cid expected %0d actual %0d",
                         $time, want.picked_cid, got.picked_cid);
            end
            if (got.same_llc !== want.same_llc)
            begin
                errors++;
                $display("%0t: same_llc expected %0d actual %0d",
                         $time, want.same_llc, got.same_llc);
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_ready;
    tacp_pkg::tacp_req_t req_data;
    logic                rsp_valid;
    logic                rsp_ready;
    tacp_pkg::tacp_rsp_t rsp_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [4:0]          paddr;
    logic [63:0]         pwdata;
    logic [63:0]         prdata;
    logic                pready;

    core_pick_tracker tracker = new();

    bit no_gaps;
    int bad_reads;
    int n_settings;
    int cycles;
    int lay_cf[64];
    int lay_cs[64];
    int lay_lf[64];
    int lay_ls[64];

    topology_aware_idle_core_picker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pause_len();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic tacp_pkg::tacp_req_t rand_req(tacp_pkg::tacp_op_t op);
        tacp_pkg::tacp_req_t r;
        r.opcode = op;
        r.cid = 6'($urandom);
        r.prev_valid = 1'($urandom);
        r.allowed_mask = {$urandom, $urandom};
        r.whole_core = 1'($urandom);
        r.pinned = 1'($urandom);
        r.core_first = 6'($urandom);
        r.core_size = 7'($urandom_range(0, 64));
        r.llc_first = 6'($urandom);
        r.llc_size = 7'($urandom_range(0, 64));
        return r;
    endfunction

    function automatic void build_layout(int cs, int ls);
        for (int id = 0; id < 64; id++)
        begin
            lay_cf[id] = id / cs * cs;
            lay_cs[id] = cs;
            lay_lf[id] = id / ls * ls;
            lay_ls[id] = ls;
        end
    endfunction

    task automatic send_op(tacp_pkg::tacp_req_t r);
        int gap;
        gap = pause_len();
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data <= r;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        tracker.note_op(r);
    endtask

    task automatic mark(tacp_pkg::tacp_op_t op, int id);
        tacp_pkg::tacp_req_t r;
        r = rand_req(op);
        r.cid = 6'(id);
        send_op(r);
    endtask

    task automatic load_entry(int id, int cf, int cs, int lf, int ls);
        tacp_pkg::tacp_req_t r;
        r = rand_req(tacp_pkg::OP_LOAD);
        r.cid = 6'(id);
        r.core_first = 6'(cf);
        r.core_size = 7'(cs);
        r.llc_first = 6'(lf);
        r.llc_size = 7'(ls);
        send_op(r);
    endtask

    task automatic restore_entry(int id);
        load_entry(id, lay_cf[id], lay_cs[id], lay_lf[id], lay_ls[id]);
    endtask

    task automatic pick(int id, bit pv, bit co, bit pin, logic [63:0] ok);
        tacp_pkg::tacp_req_t r;
        r = rand_req(tacp_pkg::OP_PICK);
        r.cid = 6'(id);
        r.prev_valid = pv;
        r.whole_core = co;
        r.pinned = pin;
        r.allowed_mask = ok;
        send_op(r);
    endtask

    task automatic drain();
        @(negedge clk);
        req_valid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [63:0] value);
        logic [63:0] keep;
        case (idx)
            tacp_pkg::REG_SEARCH_ALL:   keep = 64'h1;
            tacp_pkg::REG_PRIMARY_MASK: keep = '1;
            default:                    keep = 64'h7F;
        endcase
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if ((prdata & keep) !== (value & keep))
        begin
            bad_reads++;
            $display("%0t: readback at %0d expected %h actual %h",
                     $time, {idx, 3'b000}, value & keep, prdata & keep);
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        tracker.set_reg(idx, value);
    endtask

    task automatic configure(bit all, logic [63:0] mask, int count);
        write_reg(tacp_pkg::REG_SEARCH_ALL, 64'(all));
        write_reg(tacp_pkg::REG_PRIMARY_MASK, mask);
        write_reg(tacp_pkg::REG_CID_COUNT, 64'(count));
        n_settings++;
    endtask

    task automatic load_layout(int cs, int ls);
        build_layout(cs, ls);
        for (int id = 0; id < 64; id++)
            restore_entry(id);
    endtask

    task automatic directed_ops();
        mark(tacp_pkg::OP_MARK_IDLE, 0);
        mark(tacp_pkg::OP_MARK_IDLE, 1);
        mark(tacp_pkg::OP_MARK_IDLE, 63);
        pick(0, 1'b1, 1'b0, 1'b0, '1);
        pick(63, 1'b0, 1'b0, 1'b1, '0);
        pick(63, 1'b0, 1'b0, 1'b1, '1);
        pick(20, 1'b0, 1'b0, 1'b0, '1);
        pick(5, 1'b1, 1'b0, 1'b0, '0);
        mark(tacp_pkg::OP_MARK_IDLE, 4);
        mark(tacp_pkg::OP_MARK_IDLE, 5);
        mark(tacp_pkg::OP_MARK_IDLE, 6);
        pick(6, 1'b1, 1'b1, 1'b0, '1);
        pick(6, 1'b1, 1'b1, 1'b0, '1);
        pick(6, 1'b1, 1'b0, 1'b0, '1);
        // core range running off the top, and an empty core
        load_entry(62, 62, 64, 0, 64);
        load_entry(10, 10, 0, 8, 8);
        mark(tacp_pkg::OP_MARK_IDLE, 62);
        mark(tacp_pkg::OP_MARK_IDLE, 63);
        mark(tacp_pkg::OP_MARK_IDLE, 10);
        mark(tacp_pkg::OP_MARK_IDLE, 11);
        pick(62, 1'b1, 1'b1, 1'b0, '1);
        pick(10, 1'b1, 1'b1, 1'b0, '1);
        pick(62, 1'b1, 1'b0, 1'b0, 64'h8000_0000_0000_0000);
        restore_entry(62);
        restore_entry(10);
        mark(tacp_pkg::OP_MARK_BUSY, 63);
    endtask

    task automatic random_ops(int n);
        tacp_pkg::tacp_req_t r;
        int                  sel;
        int                  id;
        int                  lim;
        for (int k = 0; k < n; k++)
        begin
            sel = $urandom_range(0, 99);
            id = $urandom_range(0, 63);
            lim = tracker.scan_top();
            if (sel < 8 && lay_cs[id] <= 8)
            begin
                for (int j = 0; j < lay_cs[id] && lay_cf[id] + j < 64; j++)
                    mark(tacp_pkg::OP_MARK_IDLE, lay_cf[id] + j);
            end
            else if (sel < 38)
            begin
                mark(tacp_pkg::OP_MARK_IDLE, id);
            end
            else if (sel < 55)
            begin
                mark(tacp_pkg::OP_MARK_BUSY, id);
            end
            else if (sel < 60)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_op(rand_req(tacp_pkg::OP_LOAD));
                else
                    restore_entry(id);
            end
            else
            begin
                r = rand_req(tacp_pkg::OP_PICK);
                if (lim < 64 && $urandom_range(0, 9) < 7)
                    r.cid = 6'($urandom_range(0, lim - 1));
                r.prev_valid = $urandom_range(0, 99) < 85;
                r.pinned = $urandom_range(0, 99) < 8;
                r.whole_core = $urandom_range(0, 99) < 30;
                sel = $urandom_range(0, 99);
                if (sel < 50)
                    r.allowed_mask = '1;
                else if (sel < 65)
                    r.allowed_mask = r.allowed_mask | {$urandom, $urandom};
                else if (sel < 90)
                    r.allowed_mask = {$urandom, $urandom};
                else if (sel < 95)
                    r.allowed_mask = r.allowed_mask & {$urandom, $urandom};
                else
                    r.allowed_mask = '0;
                send_op(r);
            end
        end
    endtask

    initial
    begin
        int hold;
        rsp_ready = 1'b0;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                rsp_ready <= 1'b0;
                hold--;
            end
            else
            begin
                rsp_ready <= 1'b1;
                hold = pause_len();
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && rsp_ready)
                tracker.check_result(rsp_data);
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        bit          all;
        logic [63:0] mask;
        int          count;
        int          cs;
        int          ls;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        no_gaps = 1'b0;
        bad_reads = 0;
        n_settings = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    all = 1; mask = '0; count = 64; cs = 2; ls = 8;
                end
                1:
                begin
                    all = 0; mask = '1; count = 64; cs = 1; ls = 16;
                end
                2:
                begin
                    all = 0; mask = {$urandom, $urandom}; count = 64; cs = 4; ls = 64;
                end
                3:
                begin
                    all = 0; mask = '0; count = 1; cs = 2; ls = 8;
                end
                4:
                begin
                    all = 0; mask = 64'h5555_5555_5555_5555; count = 40; cs = 3; ls = 24;
                end
                5:
                begin
                    all = 1; mask = {$urandom, $urandom}; count = 64; cs = 8; ls = 32;
                end
                6:
                begin
                    all = 0; mask = {$urandom, $urandom}; count = 13; cs = 2; ls = 12;
                end
                default:
                begin
                    all = 0;
                    mask = 64'hFFFF_0000_FFFF_0000;
                    count = $urandom_range(2, 64);
                    cs = 64;
                    ls = 64;
                end
            endcase
            no_gaps = (p == 1 || p == 5);
            configure(all, mask, count);
            load_layout(cs, ls);
            if (p == 0)
                directed_ops();
            random_ops(ITEMS_PER_PHASE / 2);
            if (p == 2 || $urandom_range(0, 2) == 0)
                drain();
            random_ops(ITEMS_PER_PHASE / 2);
            drain();
        end

        repeat (20) @(posedge clk);
        $display("Ran %0d ops under %0d register settings: %0d picks, %0d claimed an id,",
                 tracker.n_ops, n_settings, tracker.n_picks, tracker.n_found);
        $display("%0d of them inside the previous id's cache domain", tracker.n_same);
        if (tracker.errors == 0 && bad_reads == 0 && tracker.outstanding() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
